[hw/rtl/elmc_pkg.sv]
// shared types and constants for the ego lane membership check
package elmc_pkg;

  localparam int MaxLanes   = 8;
  localparam int MaxPoints  = 32;
  localparam int LaneW      = $clog2(MaxLanes);
  localparam int PointW     = $clog2(MaxPoints);
  localparam int AddrW      = LaneW + PointW;
  localparam int CoordW     = 14;
  localparam int CountW     = 6;
  localparam int QueryW     = 12;
  localparam int FrameW     = 13;
  localparam int LanesW     = 4;
  localparam int CfgIdxW    = 2;

  typedef enum logic [1:0] {
    OP_WRITE_POINT = 2'd0,
    OP_SET_COUNT   = 2'd1,
    OP_QUERY       = 2'd2,
    OP_NOP         = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LANES_IN_USE = 2'd2
  } cfg_idx_e;

  // classified word handed from front to back
  typedef struct packed {
    logic                     is_query;
    logic                     is_point;
    logic                     is_count;
    logic                     fail;
    logic [LaneW-1:0]         lane;
    logic [PointW-1:0]        pt;
    logic [2*CoordW-1:0]      wdata;
    logic [CountW-1:0]        cnt;
    logic [QueryW-1:0]        qx;
    logic [QueryW-1:0]        qy;
    logic [LanesW-1:0]        lanes;
    logic [FrameW-2:0]        center;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LANE,
    ST_SEG_RD,
    ST_SEG_CHK,
    ST_DIV,
    ST_NEAR_RD,
    ST_NEAR_CHK,
    ST_NEAR_X,
    ST_NEAR_XW,
    ST_PICK,
    ST_OUT
  } state_e;

endpackage

[hw/rtl/elmc_divider.sv]
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module elmc_divider import elmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  num_i,
  input  logic signed [15:0]  den_i,
  output logic                done_o,
  output logic signed [31:0]  quo_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, num_mag;
  logic [15:0] den_q, den_d, den_mag;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[15] ? 16'(-den_i) : 16'(den_i);

  // restoring division step
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_mag;
      den_d  = den_mag;
      neg_d  = num_i[31] ^ den_i[15];
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[31]} - {17'd0, den_q};
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

[hw/rtl/elmc_front.sv]
// front end: takes input words and classifies them into jobs for the back end
module elmc_front import elmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [1:0]               opcode_i,
  input  logic [LaneW-1:0]         lane_index_i,
  input  logic [PointW-1:0]        point_index_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic [CountW-1:0]        point_count_i,
  input  logic [QueryW-1:0]        query_x_i,
  input  logic [QueryW-1:0]        query_y_i,
  input  logic [FrameW-1:0]        frame_width_i,
  input  logic [FrameW-1:0]        frame_height_i,
  input  logic [LanesW-1:0]        lanes_in_use_i,
  // queue toward the back end
  output logic                     job_valid_o,
  output job_t                     job_o,
  input  logic                     job_pop_i
);

  localparam int Depth = 2;

  job_t       fifo_q [Depth];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;
  logic       accept, fail;
  op_e        op;
  job_t       job;

  assign op     = op_e'(opcode_i);
  assign full_o = (fill_q == 2'(Depth));
  assign accept = push_i && !full_o;

  // query failure checks
  assign fail = (lanes_in_use_i < 4'd2) || (lanes_in_use_i > 4'(MaxLanes)) ||
                (frame_width_i == '0) || (frame_height_i == '0) ||
                ({1'b0, query_x_i} >= frame_width_i) ||
                ({1'b0, query_y_i} >= frame_height_i);

  // store writes travel with the job so they land in order with queries
  always_comb begin
    job.is_query = (op == OP_QUERY);
    job.is_point = (op == OP_WRITE_POINT);
    job.is_count = (op == OP_SET_COUNT);
    job.fail     = fail;
    job.lane     = lane_index_i;
    job.pt       = point_index_i;
    job.wdata    = {point_x_i, point_y_i};
    job.cnt      = point_count_i;
    job.qx       = query_x_i;
    job.qy       = query_y_i;
    job.lanes    = lanes_in_use_i;
    job.center   = frame_width_i[FrameW-1:1];
  end

  // short job queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (accept) wp_q <= !wp_q;
      if (job_pop_i) rp_q <= !rp_q;
      fill_q <= fill_q + 2'(accept) - 2'(job_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) fifo_q[wp_q] <= job;
  end

  assign job_valid_o = (fill_q != '0);
  assign job_o       = fifo_q[rp_q];

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_i |-> fill_q != '0) else $error("pop of empty job queue");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 2'(Depth)) else $error("job queue overfilled");

endmodule

[hw/rtl/elmc_back.sv]
// back end: applies store writes, walks lane points for a query, builds the result word
module elmc_back import elmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  job_t                     job_i,
  output logic                     job_pop_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic                     is_query_answer_o,
  output logic                     in_ego_lane_o,
  output logic                     left_found_o,
  output logic                     right_found_o,
  output logic signed [CoordW-1:0] left_boundary_x_o,
  output logic signed [CoordW-1:0] right_boundary_x_o
);

  logic [2*CoordW-1:0] mem_q [MaxLanes*MaxPoints];
  logic [CountW-1:0]   cnt_q [MaxLanes];
  logic [2*CoordW-1:0] rd_q;
  logic [AddrW-1:0]    raddr;
  logic                rd_en;
  logic                pt_we, cnt_we;

  state_e state_q, state_d;
  job_t   job_q, job_d;
  logic [LaneW-1:0]  lane_q, lane_d;
  logic [CountW-1:0] idx_q, idx_d, best_q, best_d, lcnt;
  logic signed [CoordW-1:0] x0_q, x0_d, y0_q, y0_d, lx_q, lx_d, rx_q, rx_d;
  logic signed [CoordW-1:0] lanex_q, lanex_d;
  logic signed [CoordW+1:0] bestd_q, bestd_d, ydist;
  logic fl_q, fl_d, fr_q, fr_d;
  logic out_v_q, out_v_d, pop_job;
  logic o_q_q, o_q_d, o_in_q, o_in_d;
  logic div_start, div_done;
  logic signed [31:0] div_num_q, div_num_d, div_quo;
  logic signed [15:0] div_den_q, div_den_d;
  logic signed [CoordW-1:0] rx1, ry1;
  logic signed [CoordW:0]   qy_s, cen_s;
  logic lane_valid;

  // store writes are applied when their job is taken
  assign pt_we  = pop_job && job_i.is_point;
  assign cnt_we = pop_job && job_i.is_count;

  // point memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (pt_we) mem_q[{job_i.lane, job_i.pt}] <= job_i.wdata;
    if (rd_en) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLanes; i++) cnt_q[i] <= '0;
    end else if (cnt_we) begin
      cnt_q[job_i.lane] <= job_i.cnt;
    end
  end

  elmc_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num_q), .den_i(div_den_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign lcnt       = cnt_q[lane_q];
  assign lane_valid = (lcnt != '0) && (lcnt <= CountW'(MaxPoints));
  assign rx1        = rd_q[2*CoordW-1:CoordW];
  assign ry1        = rd_q[CoordW-1:0];
  assign qy_s       = $signed({3'b0, job_q.qy});
  assign cen_s      = $signed({3'b0, job_q.center});
  assign ydist      = (ry1 - qy_s) < 0 ? -(ry1 - qy_s) : (ry1 - qy_s);

  // query sequencer
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    lane_d    = lane_q;
    idx_d     = idx_q;
    best_d    = best_q;
    x0_d      = x0_q;
    y0_d      = y0_q;
    lx_d      = lx_q;
    rx_d      = rx_q;
    lanex_d   = lanex_q;
    bestd_d   = bestd_q;
    fl_d      = fl_q;
    fr_d      = fr_q;
    out_v_d   = out_v_q;
    o_q_d     = o_q_q;
    o_in_d    = o_in_q;
    div_num_d = div_num_q;
    div_den_d = div_den_q;
    div_start = 1'b0;
    pop_job   = 1'b0;
    rd_en     = 1'b0;
    raddr     = {lane_q, idx_q[PointW-1:0]};
    if (out_v_q && pop_i) out_v_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_job = 1'b1;
          job_d   = job_i;
          lane_d  = '0;
          fl_d    = 1'b0;
          fr_d    = 1'b0;
          lx_d    = '0;
          rx_d    = '0;
          if (!job_i.is_query || job_i.fail) state_d = ST_OUT;
          else                               state_d = ST_LANE;
        end
      end
      ST_LANE: begin
        idx_d = '0;
        if (!lane_valid) begin
          state_d = ST_PICK;
        end else begin
          raddr   = {lane_q, PointW'(0)};
          rd_en   = 1'b1;
          state_d = (lcnt == CountW'(1)) ? ST_NEAR_X : ST_SEG_RD;
          best_d  = '0;
        end
      end
      ST_SEG_RD: begin
        // first point of the lane now in rd_q
        x0_d  = rx1;
        y0_d  = ry1;
        idx_d = idx_q + 1'b1;
        raddr = {lane_q, PointW'(idx_q + 1'b1)};
        rd_en = 1'b1;
        state_d = ST_SEG_CHK;
      end
      ST_SEG_CHK: begin
        if ((qy_s >= y0_q && qy_s <= ry1) || (qy_s >= ry1 && qy_s <= y0_q)) begin
          if (ry1 == y0_q) begin
            lanex_d = x0_q;
            state_d = ST_PICK;
          end else begin
            div_num_d = 32'(($signed(rx1) - x0_q) * (qy_s - y0_q));
            div_den_d = 16'(ry1 - y0_q);
            state_d   = ST_DIV;
            div_start = 1'b0;
          end
        end else if (idx_q + 1'b1 >= lcnt) begin
          idx_d   = '0;
          raddr   = {lane_q, PointW'(0)};
          rd_en   = 1'b1;
          state_d = ST_NEAR_RD;
        end else begin
          x0_d  = rx1;
          y0_d  = ry1;
          idx_d = idx_q + 1'b1;
          raddr = {lane_q, PointW'(idx_q + 1'b1)};
          rd_en = 1'b1;
        end
      end
      ST_DIV: begin
        // operands registered last cycle; idx_q marks start issued
        if (idx_q != '1) begin
          div_start = 1'b1;
          idx_d     = '1;
        end else if (div_done) begin
          lanex_d = CoordW'(x0_q + div_quo);
          state_d = ST_PICK;
        end
      end
      ST_NEAR_RD: begin
        bestd_d = ydist;
        best_d  = '0;
        idx_d   = CountW'(1);
        raddr   = {lane_q, PointW'(1)};
        rd_en   = 1'b1;
        state_d = ST_NEAR_CHK;
      end
      ST_NEAR_CHK: begin
        if (ydist < bestd_q) begin
          bestd_d = ydist;
          best_d  = idx_q;
        end
        if (idx_q + 1'b1 >= lcnt) begin
          state_d = ST_NEAR_X;
          raddr   = {lane_q, (ydist < bestd_q) ? idx_q[PointW-1:0] : best_q[PointW-1:0]};
          rd_en   = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
          raddr = {lane_q, PointW'(idx_q + 1'b1)};
          rd_en = 1'b1;
        end
      end
      ST_NEAR_X: state_d = ST_NEAR_XW;
      ST_NEAR_XW: begin
        lanex_d = rx1;
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (lane_valid) begin
          if ($signed({lanex_q[CoordW-1], lanex_q}) < cen_s) begin
            if (!fl_q || lanex_q > lx_q) begin
              lx_d = lanex_q;
              fl_d = 1'b1;
            end
          end else if ($signed({lanex_q[CoordW-1], lanex_q}) > cen_s) begin
            if (!fr_q || lanex_q < rx_q) begin
              rx_d = lanex_q;
              fr_d = 1'b1;
            end
          end
        end
        if (LanesW'(lane_q) + 1'b1 >= job_q.lanes) state_d = ST_OUT;
        else begin
          lane_d  = lane_q + 1'b1;
          state_d = ST_LANE;
        end
      end
      ST_OUT: begin
        if (!out_v_q || pop_i) begin
          out_v_d = 1'b1;
          o_q_d   = job_q.is_query;
          o_in_d  = fl_q && fr_q && (lx_q < rx_q) &&
                    ($signed({2'b0, job_q.qx}) > lx_q) &&
                    ($signed({2'b0, job_q.qx}) < rx_q);
          if (!job_q.is_query || job_q.fail) begin
            fl_d = 1'b0;
            fr_d = 1'b0;
            lx_d = '0;
            rx_d = '0;
            o_in_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    lane_q    <= lane_d;
    idx_q     <= idx_d;
    best_q    <= best_d;
    x0_q      <= x0_d;
    y0_q      <= y0_d;
    lanex_q   <= lanex_d;
    bestd_q   <= bestd_d;
    div_num_q <= div_num_d;
    div_den_q <= div_den_d;
    if (state_q == ST_OUT && state_d == ST_IDLE) begin
      o_q_q <= o_q_d;
      o_in_q <= o_in_d;
    end
  end

  // result word registers
  logic fl_o_q, fr_o_q;
  logic signed [CoordW-1:0] lx_o_q, rx_o_q;
  always_ff @(posedge clk_i) begin
    fl_q <= fl_d;
    fr_q <= fr_d;
    lx_q <= lx_d;
    rx_q <= rx_d;
    if (state_q == ST_OUT && state_d == ST_IDLE) begin
      fl_o_q <= fl_d;
      fr_o_q <= fr_d;
      lx_o_q <= lx_d;
      rx_o_q <= rx_d;
    end
  end

  assign job_pop_o          = pop_job;
  assign empty_o            = !out_v_q;
  assign is_query_answer_o  = o_q_q;
  assign in_ego_lane_o      = o_in_q;
  assign left_found_o       = fl_o_q;
  assign right_found_o      = fr_o_q;
  assign left_boundary_x_o  = lx_o_q;
  assign right_boundary_x_o = rx_o_q;

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> state_q == ST_DIV) else $error("divider started outside divide state");
  a_in_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && in_ego_lane_o) |-> (left_found_o && right_found_o))
    else $error("inside without both boundaries");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pop_i) |=> out_v_q && $stable(in_ego_lane_o))
    else $error("result changed while waiting");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> state_q == ST_IDLE) else $error("job taken while busy");

endmodule

[hw/rtl/ego_lane_membership_check.sv]
// top level of the ego lane membership check
// a point or count write is applied when it is taken; a query walks each lane in use
// in turn: an empty lane is skipped, a crossed segment is interpolated with the
// bit-serial divider, and otherwise the nearest point by row is searched, all through
// the single point memory read port. one word is worked on at a time; two may wait
// in front.
// reset clears counts, queue and registers to frame 1280x720, no lanes in use.
module ego_lane_membership_check import elmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               opcode_i,
  input  logic [LaneW-1:0]         lane_index_i,
  input  logic [PointW-1:0]        point_index_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic [CountW-1:0]        point_count_i,
  input  logic [QueryW-1:0]        query_x_i,
  input  logic [QueryW-1:0]        query_y_i,
  output logic                     empty,
  input  logic                     pop,
  output logic                     is_query_answer_o,
  output logic                     in_ego_lane_o,
  output logic                     left_found_o,
  output logic                     right_found_o,
  output logic signed [CoordW-1:0] left_boundary_x_o,
  output logic signed [CoordW-1:0] right_boundary_x_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [15:0]              cfg_data_i
);

  logic [FrameW-1:0] fw_q, fh_q;
  logic [LanesW-1:0] lanes_q;
  logic job_valid, job_pop;
  job_t job;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= FrameW'(1280);
      fh_q    <= FrameW'(720);
      lanes_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  fw_q    <= cfg_data_i[FrameW-1:0];
        CFG_FRAME_HEIGHT: fh_q    <= cfg_data_i[FrameW-1:0];
        CFG_LANES_IN_USE: lanes_q <= cfg_data_i[LanesW-1:0];
        default: ;
      endcase
    end
  end

  elmc_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .opcode_i, .lane_index_i, .point_index_i, .point_x_i, .point_y_i,
    .point_count_i, .query_x_i, .query_y_i,
    .frame_width_i(fw_q), .frame_height_i(fh_q), .lanes_in_use_i(lanes_q),
    .job_valid_o(job_valid), .job_o(job), .job_pop_i(job_pop)
  );

  elmc_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .empty_o(empty), .pop_i(pop),
    .is_query_answer_o, .in_ego_lane_o, .left_found_o, .right_found_o,
    .left_boundary_x_o, .right_boundary_x_o
  );

endmodule
